/* rtl/flbs_pkg.sv */
// Shared types, constants and register indexes for the finest-level box search.
package flbs_pkg;

    // Table geometry
    localparam int MAX_BOXES  = 64;
    localparam int MAX_LEVELS = 16;
    localparam int BOX_AW     = $clog2(MAX_BOXES);
    localparam int NUM_AXES   = 3;

    // Field widths
    localparam int COORD_W = 32;
    localparam int SPACE_W = 24;
    localparam int CELLS_W = 13;
    localparam int LEVEL_W = 4;
    localparam int SLOT_W  = 6;
    localparam int COUNT_W = 7;
    localparam int DIMS_W  = 2;
    localparam int TOL_W   = 16;
    localparam int PROD_W  = SPACE_W + CELLS_W;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIMENSIONS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE  = 2'd2;

    // Item actions
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // Axis codes
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic [DIMS_W-1:0] DIMS_TWO = 2'd2;

    typedef struct packed {
        logic                      action;
        logic [SLOT_W-1:0]         slot;
        logic [LEVEL_W-1:0]        level;
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic signed [COORD_W-1:0] coord_z;
        logic [SPACE_W-1:0]        spacing_x;
        logic [SPACE_W-1:0]        spacing_y;
        logic [SPACE_W-1:0]        spacing_z;
        logic [CELLS_W-1:0]        cells_x;
        logic [CELLS_W-1:0]        cells_y;
        logic [CELLS_W-1:0]        cells_z;
    } t_in_item;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] donor_index;
    } t_out_item;

    // One row of the box table
    typedef struct packed {
        logic [LEVEL_W-1:0]                 level;
        logic [NUM_AXES-1:0][COORD_W-1:0]   low;
        logic [NUM_AXES-1:0][COORD_W-1:0]   high;
    } t_box_entry;

    localparam int ENTRY_W = $bits(t_box_entry);

    // Controller to datapath
    typedef struct packed {
        logic              capture;
        logic              mul;
        logic              add;
        logic [1:0]        axis;
        logic              wr;
        logic              clear_best;
        logic              rd_en;
        logic [BOX_AW-1:0] rd_addr;
        logic              out_load;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic               action;
        logic               count_zero;
        logic [COUNT_W-1:0] scan_last;
        logic               out_free;
    } t_dp_stat;

endpackage

/* rtl/flbs_ram.sv */
// Generic single-port-write, registered-read RAM.
module flbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/flbs_ctrl.sv */
// Sequencer for box loads and query scans.
module flbs_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  flbs_pkg::t_dp_stat i_stat,
    output flbs_pkg::t_dp_cmd  o_cmd
);
    import flbs_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LD_MUL = 3'd1;
    localparam logic [2:0] S_LD_ADD = 3'd2;
    localparam logic [2:0] S_LD_WR  = 3'd3;
    localparam logic [2:0] S_SCAN   = 3'd4;
    localparam logic [2:0] S_LAST   = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0]        r_state, n_state;
    logic [1:0]        r_axis, n_axis;
    logic [BOX_AW-1:0] r_idx, n_idx;
    logic              w_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    // Next state and command decode
    always_comb begin
        n_state = r_state;
        n_axis  = r_axis;
        n_idx   = r_idx;
        o_cmd   = '0;
        o_cmd.axis    = r_axis;
        o_cmd.rd_addr = r_idx;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.capture = 1'b1;
                    n_axis = AXIS_X;
                    n_idx  = '0;
                    if (i_stat.action == ACT_QUERY) begin
                        o_cmd.clear_best = 1'b1;
                        n_state = i_stat.count_zero ? S_DONE : S_SCAN;
                    end else begin
                        n_state = S_LD_MUL;
                    end
                end
            end
            S_LD_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = S_LD_ADD;
            end
            S_LD_ADD: begin
                o_cmd.add = 1'b1;
                if (r_axis == AXIS_Z) begin
                    n_state = S_LD_WR;
                end else begin
                    n_axis  = r_axis + 2'd1;
                    n_state = S_LD_MUL;
                end
            end
            S_LD_WR: begin
                o_cmd.wr = 1'b1;
                n_state = S_IDLE;
            end
            S_SCAN: begin
                o_cmd.rd_en = 1'b1;
                if (COUNT_W'(r_idx) == i_stat.scan_last) begin
                    n_state = S_LAST;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_LAST: begin
                // last box is compared in the datapath this cycle
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_axis  <= AXIS_X;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_axis  <= n_axis;
            r_idx   <= n_idx;
        end
    end

endmodule

/* rtl/flbs_dp.sv */
// Datapath: config registers, corner arithmetic, box table, compare and best tracking.
module flbs_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [flbs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [flbs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  flbs_pkg::t_in_item              i_in,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output flbs_pkg::t_out_item             o_out,
    input  flbs_pkg::t_dp_cmd               i_cmd,
    output flbs_pkg::t_dp_stat              o_stat
);
    import flbs_pkg::*;

    // Configuration registers
    logic [COUNT_W-1:0] r_box_count;
    logic [DIMS_W-1:0]  r_dims;
    logic [TOL_W-1:0]   r_tol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_count <= '0;
            r_dims      <= 2'd3;
            r_tol       <= 16'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_BOX_COUNT:  r_box_count <= i_cfg_data[COUNT_W-1:0];
                REG_DIMENSIONS: r_dims      <= i_cfg_data[DIMS_W-1:0];
                REG_TOLERANCE:  r_tol       <= i_cfg_data[TOL_W-1:0];
                default: ;
            endcase
        end
    end

    // Searched slot count, clamped to the table
    logic [COUNT_W-1:0] w_count;
    assign w_count = (r_box_count > COUNT_W'(MAX_BOXES)) ? COUNT_W'(MAX_BOXES) : r_box_count;

    // Captured item
    t_in_item r_item;
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_in;
        end
    end

    // Per-axis operand select for the load
    logic [COORD_W-1:0] w_lo;
    logic [SPACE_W-1:0] w_sp;
    logic [CELLS_W-1:0] w_nc;
    always_comb begin
        unique case (i_cmd.axis)
            AXIS_X: begin
                w_lo = r_item.coord_x;
                w_sp = r_item.spacing_x;
                w_nc = r_item.cells_x;
            end
            AXIS_Y: begin
                w_lo = r_item.coord_y;
                w_sp = r_item.spacing_y;
                w_nc = r_item.cells_y;
            end
            default: begin
                w_lo = r_item.coord_z;
                w_sp = r_item.spacing_z;
                w_nc = r_item.cells_z;
            end
        endcase
    end

    // Extent product, one axis per pass
    logic [PROD_W-1:0] r_prod;
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= {{CELLS_W{1'b0}}, w_sp} * {{SPACE_W{1'b0}}, w_nc};
        end
    end

    // Upper corner = lower + extent, saturated to 32 bits
    localparam int SUM_W = PROD_W + 2;
    logic [SUM_W-1:0]   w_sum;
    logic [COORD_W-1:0] w_high;
    logic               w_pos_ovf;
    logic               w_neg_ovf;
    assign w_sum = {{(SUM_W-COORD_W){w_lo[COORD_W-1]}}, w_lo} + {2'b00, r_prod};
    assign w_pos_ovf = !w_sum[SUM_W-1] && (|w_sum[SUM_W-2:COORD_W-1]);
    assign w_neg_ovf = w_sum[SUM_W-1] && !(&w_sum[SUM_W-2:COORD_W-1]);
    always_comb begin
        priority if (w_pos_ovf) begin
            w_high = {1'b0, {(COORD_W-1){1'b1}}};
        end else if (w_neg_ovf) begin
            w_high = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            w_high = w_sum[COORD_W-1:0];
        end
    end

    logic [NUM_AXES-1:0][COORD_W-1:0] r_high;
    always_ff @(posedge i_clk) begin
        if (i_cmd.add) begin
            unique case (i_cmd.axis)
                AXIS_X:  r_high[0] <= w_high;
                AXIS_Y:  r_high[1] <= w_high;
                default: r_high[2] <= w_high;
            endcase
        end
    end

    // Table write data; level clamped to the level range
    t_box_entry w_wentry;
    logic       w_wr_en;
    always_comb begin
        w_wentry.level = (COUNT_W'(r_item.level) >= COUNT_W'(MAX_LEVELS)) ?
                         LEVEL_W'(MAX_LEVELS - 1) : r_item.level;
        w_wentry.low[0] = r_item.coord_x;
        w_wentry.low[1] = r_item.coord_y;
        w_wentry.low[2] = r_item.coord_z;
        w_wentry.high   = r_high;
    end
    assign w_wr_en = i_cmd.wr && (COUNT_W'(r_item.slot) < COUNT_W'(MAX_BOXES));

    // Box table
    t_box_entry w_rentry;
    flbs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_BOXES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_wr_en),
        .i_waddr (r_item.slot[BOX_AW-1:0]),
        .i_wdata (w_wentry),
        .i_re    (i_cmd.rd_en),
        .i_raddr (i_cmd.rd_addr),
        .o_rdata (w_rentry)
    );

    // Read data arrives in the cycle after the address
    logic              r_chk_valid;
    logic [BOX_AW-1:0] r_chk_idx;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chk_valid <= 1'b0;
        end else begin
            r_chk_valid <= i_cmd.rd_en;
        end
    end
    always_ff @(posedge i_clk) begin
        r_chk_idx <= i_cmd.rd_addr;
    end

    // Containment test, axes in parallel
    logic [NUM_AXES-1:0][COORD_W-1:0] w_pt;
    logic [NUM_AXES-1:0]              w_axis_ok;
    logic [COORD_W:0]                 w_dlo [NUM_AXES];
    logic [COORD_W:0]                 w_dhi [NUM_AXES];
    logic [COORD_W+1:0]               w_lo_sum [NUM_AXES];
    logic [COORD_W+1:0]               w_hi_sum [NUM_AXES];
    logic                             w_inside;

    assign w_pt[0] = r_item.coord_x;
    assign w_pt[1] = r_item.coord_y;
    assign w_pt[2] = r_item.coord_z;

    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            w_dlo[a] = {w_pt[a][COORD_W-1], w_pt[a]} -
                       {w_rentry.low[a][COORD_W-1], w_rentry.low[a]};
            w_dhi[a] = {w_pt[a][COORD_W-1], w_pt[a]} -
                       {w_rentry.high[a][COORD_W-1], w_rentry.high[a]};
            // p - low + tol > 0
            w_lo_sum[a] = {w_dlo[a][COORD_W], w_dlo[a]} +
                          {{(COORD_W+2-TOL_W){1'b0}}, r_tol};
            // p - high - tol < 0
            w_hi_sum[a] = {w_dhi[a][COORD_W], w_dhi[a]} -
                          {{(COORD_W+2-TOL_W){1'b0}}, r_tol};
            w_axis_ok[a] = !w_lo_sum[a][COORD_W+1] && (|w_lo_sum[a]) &&
                           w_hi_sum[a][COORD_W+1];
        end
    end
    assign w_inside = w_axis_ok[0] && w_axis_ok[1] && (w_axis_ok[2] || (r_dims == DIMS_TWO));

    // Best box so far: highest level, first slot on ties
    logic               r_have;
    logic [BOX_AW-1:0]  r_best_idx;
    logic [LEVEL_W-1:0] r_best_lvl;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
        end else if (i_cmd.clear_best) begin
            r_have <= 1'b0;
        end else if (r_chk_valid && w_inside) begin
            r_have <= 1'b1;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_best) begin
            r_best_idx <= '0;
            r_best_lvl <= '0;
        end else if (r_chk_valid && w_inside && (!r_have || (w_rentry.level > r_best_lvl))) begin
            r_best_idx <= r_chk_idx;
            r_best_lvl <= w_rentry.level;
        end
    end

    // Output register
    logic      r_out_valid;
    t_out_item r_out;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.found       <= r_have;
            r_out.donor_index <= r_have ? SLOT_W'(r_best_idx) : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Status to the controller
    assign o_stat.action     = i_in.action;
    assign o_stat.count_zero = (w_count == '0);
    assign o_stat.scan_last  = w_count - 1'b1;
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

endmodule

/* rtl/finest_level_box_search.sv */
// Top level of the finest-level box search.
// Loads fill a 64-entry box table; queries return the containing box on the
// finest level (lowest slot on ties). In a load, the upper corner of each axis
// goes through one shared 24x13 multiplier and a saturating adder, one axis
// after another, then the table row is written. A query scans n = min(box_count,
// 64) rows, or none when n is zero: the scan reads one table row per cycle
// through the table's single read port and tests it on all axes at once.
// The result sits in an output register, so the next item can be taken while
// it waits; a query result is held back only until that register is free.
module finest_level_box_search (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  flbs_pkg::t_in_item              i_in,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output flbs_pkg::t_out_item             o_out,
    input  logic                            i_cfg_we,
    input  logic [flbs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [flbs_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import flbs_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    flbs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    flbs_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat)
    );

endmodule

/* rtl/flbs_checker.sv */
// Port-level assertions for the finest-level box search, bound to the top level.
module flbs_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_ready,
    input flbs_pkg::t_in_item              i_in,
    input logic                            o_out_valid,
    input logic                            i_out_ready,
    input flbs_pkg::t_out_item             o_out
);
    import flbs_pkg::*;

    logic w_query_acc;
    logic w_out_acc;
    logic [1:0] r_pend;

    assign w_query_acc = i_in_valid && o_in_ready && (i_in.action == ACT_QUERY);
    assign w_out_acc   = o_out_valid && i_out_ready;

    // Queries accepted but not yet answered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + {1'b0, w_query_acc} - {1'b0, w_out_acc};
        end
    end

    // A result is shown only for an outstanding query
    a_out_has_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_pend != 2'd0))
        else $error("result without an outstanding query");

    // At most one query in work plus one result waiting
    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend != 2'd3))
        else $error("too many outstanding queries");

    // A query occupies the block for at least the next cycle
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_query_acc |=> !o_in_ready)
        else $error("item taken right after a query");

    // Not found always reports slot zero
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.found) |-> (o_out.donor_index == '0))
        else $error("miss with nonzero slot");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out)))
        else $error("stalled result changed");

endmodule

bind finest_level_box_search flbs_checker u_flbs_checker (.*);
